// ===== rtl/bpi_pkg.sv =====
package bpi_pkg;

  localparam int NUM_W = 58;
  localparam int DEN_W = 33;
  localparam int Q_W   = 25;
  localparam logic [8:0] RESTITUTION_RST = 9'd256;
  localparam logic [8:0] RESTITUTION_MAX = 9'd256;

  typedef struct packed {
    logic        [15:0] a_pos_x;
    logic        [15:0] a_pos_y;
    logic signed [15:0] a_vel_x;
    logic signed [15:0] a_vel_y;
    logic        [11:0] a_radius;
    logic        [15:0] b_pos_x;
    logic        [15:0] b_pos_y;
    logic signed [15:0] b_vel_x;
    logic signed [15:0] b_vel_y;
    logic        [11:0] b_radius;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] new_a_vel_x;
    logic signed [15:0] new_a_vel_y;
    logic signed [15:0] new_b_vel_x;
    logic signed [15:0] new_b_vel_y;
    logic               touching;
    logic               impulse_applied;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] vax;
    logic signed [15:0] vay;
    logic signed [15:0] vbx;
    logic signed [15:0] vby;
    logic               touching;
    logic               hit;
    logic               px_neg;
    logic               py_neg;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_px;
    logic [NUM_W-1:0] num_py;
    logic [NUM_W-1:0] num_wa;
    logic [NUM_W-1:0] num_wb;
    logic [DEN_W-1:0] den_p;
    logic [DEN_W-1:0] den_w;
    side_t            side;
  } front_t;

endpackage

// ===== rtl/bpi_front.sv =====
module bpi_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  bpi_pkg::in_item_t  in_item,
  input  logic [8:0]         restitution,
  output logic               out_v,
  output bpi_pkg::front_t    out_f
);

  // stage 1: differences
  logic               v1_r;
  logic signed [16:0] dx1_r, dy1_r, vrx1_r, vry1_r;
  logic        [12:0] rs1_r;
  logic        [11:0] ra1_r, rb1_r;
  logic        [9:0]  ep1_r;
  logic signed [15:0] vax1_r, vay1_r, vbx1_r, vby1_r;

  // stage 2: products
  logic               v2_r;
  logic        [31:0] dxsq2_r, dysq2_r;
  logic        [25:0] rssq2_r;
  logic signed [33:0] sx2_r, sy2_r;
  logic        [23:0] ma2_r, mb2_r;
  logic signed [16:0] dx2_r, dy2_r;
  logic        [9:0]  ep2_r;
  logic signed [15:0] vax2_r, vay2_r, vbx2_r, vby2_r;

  // stage 3: sums and flags
  logic               v3_r;
  logic        [32:0] d23_r;
  logic signed [34:0] s3_r;
  logic        [24:0] msum3_r;
  logic               touch3_r, hit3_r;
  logic signed [16:0] dx3_r, dy3_r;
  logic        [23:0] ma3_r, mb3_r;
  logic        [9:0]  ep3_r;
  logic signed [15:0] vax3_r, vay3_r, vbx3_r, vby3_r;

  // stage 4: numerators
  logic               v4_r;
  logic signed [51:0] pxp4_r, pyp4_r;
  logic        [33:0] wan4_r, wbn4_r;
  logic        [32:0] d24_r;
  logic        [24:0] msum4_r;
  logic               touch4_r, hit4_r;
  logic signed [15:0] vax4_r, vay4_r, vbx4_r, vby4_r;

  // stage 5: magnitudes with rounding offset
  logic               v5_r;
  bpi_pkg::front_t    f5_r;

  logic signed [33:0] dxsq_w, dysq_w;
  logic        [25:0] rssq_w;
  logic signed [51:0] pxa_w, pya_w;

  assign dxsq_w = dx1_r * dx1_r;
  assign dysq_w = dy1_r * dy1_r;
  assign rssq_w = 26'(rs1_r) * 26'(rs1_r);
  assign pxa_w  = pxp4_r[51] ? -pxp4_r : pxp4_r;
  assign pya_w  = pyp4_r[51] ? -pyp4_r : pyp4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r  <= signed'({1'b0, in_item.b_pos_x}) - signed'({1'b0, in_item.a_pos_x});
      dy1_r  <= signed'({1'b0, in_item.b_pos_y}) - signed'({1'b0, in_item.a_pos_y});
      vrx1_r <= 17'(in_item.b_vel_x) - 17'(in_item.a_vel_x);
      vry1_r <= 17'(in_item.b_vel_y) - 17'(in_item.a_vel_y);
      rs1_r  <= {1'b0, in_item.a_radius} + {1'b0, in_item.b_radius};
      ra1_r  <= in_item.a_radius;
      rb1_r  <= in_item.b_radius;
      ep1_r  <= (restitution > bpi_pkg::RESTITUTION_MAX) ? 10'd512
                : 10'd256 + {1'b0, restitution};
      vax1_r <= in_item.a_vel_x;
      vay1_r <= in_item.a_vel_y;
      vbx1_r <= in_item.b_vel_x;
      vby1_r <= in_item.b_vel_y;

      dxsq2_r <= dxsq_w[31:0];
      dysq2_r <= dysq_w[31:0];
      rssq2_r <= rssq_w;
      sx2_r   <= vrx1_r * dx1_r;
      sy2_r   <= vry1_r * dy1_r;
      ma2_r   <= 24'(ra1_r) * 24'(ra1_r);
      mb2_r   <= 24'(rb1_r) * 24'(rb1_r);
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      ep2_r   <= ep1_r;
      vax2_r  <= vax1_r;
      vay2_r  <= vay1_r;
      vbx2_r  <= vbx1_r;
      vby2_r  <= vby1_r;

      d23_r    <= {1'b0, dxsq2_r} + {1'b0, dysq2_r};
      s3_r     <= 35'(sx2_r) + 35'(sy2_r);
      msum3_r  <= {1'b0, ma2_r} + {1'b0, mb2_r};
      touch3_r <= ({1'b0, dxsq2_r} + {1'b0, dysq2_r}) < 33'(rssq2_r);
      hit3_r   <= (({1'b0, dxsq2_r} + {1'b0, dysq2_r}) < 33'(rssq2_r))
                  && (({1'b0, dxsq2_r} + {1'b0, dysq2_r}) != 33'd0)
                  && ((35'(sx2_r) + 35'(sy2_r)) < 0)
                  && (({1'b0, ma2_r} + {1'b0, mb2_r}) != 25'd0);
      dx3_r    <= dx2_r;
      dy3_r    <= dy2_r;
      ma3_r    <= ma2_r;
      mb3_r    <= mb2_r;
      ep3_r    <= ep2_r;
      vax3_r   <= vax2_r;
      vay3_r   <= vay2_r;
      vbx3_r   <= vbx2_r;
      vby3_r   <= vby2_r;

      pxp4_r   <= 52'(s3_r) * 52'(dx3_r);
      pyp4_r   <= 52'(s3_r) * 52'(dy3_r);
      wan4_r   <= 34'(ep3_r) * 34'(mb3_r);
      wbn4_r   <= 34'(ep3_r) * 34'(ma3_r);
      d24_r    <= d23_r;
      msum4_r  <= msum3_r;
      touch4_r <= touch3_r;
      hit4_r   <= hit3_r;
      vax4_r   <= vax3_r;
      vay4_r   <= vay3_r;
      vbx4_r   <= vbx3_r;
      vby4_r   <= vby3_r;

      f5_r.num_px <= {pxa_w[49:0], 8'h00} + bpi_pkg::NUM_W'(d24_r[32:1]);
      f5_r.num_py <= {pya_w[49:0], 8'h00} + bpi_pkg::NUM_W'(d24_r[32:1]);
      f5_r.num_wa <= bpi_pkg::NUM_W'({wan4_r, 8'h00}) + bpi_pkg::NUM_W'(msum4_r[24:1]);
      f5_r.num_wb <= bpi_pkg::NUM_W'({wbn4_r, 8'h00}) + bpi_pkg::NUM_W'(msum4_r[24:1]);
      f5_r.den_p  <= d24_r;
      f5_r.den_w  <= bpi_pkg::DEN_W'(msum4_r);
      f5_r.side.vax      <= vax4_r;
      f5_r.side.vay      <= vay4_r;
      f5_r.side.vbx      <= vbx4_r;
      f5_r.side.vby      <= vby4_r;
      f5_r.side.touching <= touch4_r;
      f5_r.side.hit      <= hit4_r;
      f5_r.side.px_neg   <= pxp4_r[51];
      f5_r.side.py_neg   <= pyp4_r[51];
    end
  end

  assign out_v = v5_r;
  assign out_f = f5_r;

endmodule

// ===== rtl/bpi_div.sv =====
module bpi_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bpi_pkg::NUM_W-1:0]   num,
  input  logic [bpi_pkg::DEN_W-1:0]   den,
  output logic [bpi_pkg::Q_W-1:0]     quo
);

  localparam int NW = bpi_pkg::NUM_W;
  localparam int DW = bpi_pkg::DEN_W;
  localparam int QW = bpi_pkg::Q_W;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stg
    logic [NW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] q_i;
    logic [NW:0]   sub;

    if (i == 0) begin : g_first
      assign rem_i = num;
      assign den_i = den;
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = rem_r[i-1];
      assign den_i = den_r[i-1];
      assign q_i   = q_r[i-1];
    end

    assign sub = {1'b0, rem_i} - ((NW+1)'(den_i) << (QW - 1 - i));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= sub[NW] ? rem_i : sub[NW-1:0];
        den_r[i] <= den_i;
        q_r[i]   <= q_i | (sub[NW] ? '0 : (QW'(1) << (QW - 1 - i)));
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ===== rtl/bpi_back.sv =====
module bpi_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [bpi_pkg::Q_W-1:0]  qpx,
  input  logic [bpi_pkg::Q_W-1:0]  qpy,
  input  logic [bpi_pkg::Q_W-1:0]  qwa,
  input  logic [bpi_pkg::Q_W-1:0]  qwb,
  input  bpi_pkg::side_t           side,
  output logic                     out_v,
  output bpi_pkg::out_item_t       out_item
);

  localparam int PW = 2 * bpi_pkg::Q_W;

  logic           v1_r, v2_r, v3_r;
  logic [PW-1:0]  ax1_r, ay1_r, bx1_r, by1_r;
  bpi_pkg::side_t s1_r, s2_r;
  logic signed [26:0] cax2_r, cay2_r, cbx2_r, cby2_r;
  bpi_pkg::out_item_t o3_r;

  logic [PW-1:0] rax_w, ray_w, rbx_w, rby_w;
  logic signed [27:0] nax_w, nay_w, nbx_w, nby_w;

  function automatic logic signed [26:0] apply_sign(input logic [PW-1:0] r, input logic neg);
    logic signed [26:0] c;
    c = signed'({1'b0, r[PW-1-(PW-50):24]});
    return neg ? -c : c;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [27:0] x);
    if (x > 28'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -28'sd32768) begin
      return 16'sh8000;
    end else begin
      return x[15:0];
    end
  endfunction

  assign rax_w = ax1_r + (PW'(1) << 23);
  assign ray_w = ay1_r + (PW'(1) << 23);
  assign rbx_w = bx1_r + (PW'(1) << 23);
  assign rby_w = by1_r + (PW'(1) << 23);

  assign nax_w = 28'(s2_r.vax) + 28'(cax2_r);
  assign nay_w = 28'(s2_r.vay) + 28'(cay2_r);
  assign nbx_w = 28'(s2_r.vbx) + 28'(cbx2_r);
  assign nby_w = 28'(s2_r.vby) + 28'(cby2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= PW'(qpx) * PW'(qwa);
      ay1_r <= PW'(qpy) * PW'(qwa);
      bx1_r <= PW'(qpx) * PW'(qwb);
      by1_r <= PW'(qpy) * PW'(qwb);
      s1_r  <= side;

      cax2_r <= s1_r.hit ? apply_sign(rax_w, s1_r.px_neg) : 27'sd0;
      cay2_r <= s1_r.hit ? apply_sign(ray_w, s1_r.py_neg) : 27'sd0;
      cbx2_r <= s1_r.hit ? apply_sign(rbx_w, !s1_r.px_neg) : 27'sd0;
      cby2_r <= s1_r.hit ? apply_sign(rby_w, !s1_r.py_neg) : 27'sd0;
      s2_r   <= s1_r;

      o3_r.new_a_vel_x     <= sat16(nax_w);
      o3_r.new_a_vel_y     <= sat16(nay_w);
      o3_r.new_b_vel_x     <= sat16(nbx_w);
      o3_r.new_b_vel_y     <= sat16(nby_w);
      o3_r.touching        <= s2_r.touching;
      o3_r.impulse_applied <= s2_r.hit;
    end
  end

  assign out_v    = v3_r;
  assign out_item = o3_r;

endmodule

// ===== rtl/ball_pair_impulse_response.sv =====
// Channel  Ports                               Payload
// in       in_valid, in_ready, in_item         bpi_pkg::in_item_t
// out      out_valid, out_ready, out_item      bpi_pkg::out_item_t
// cfg      cfg_we, cfg_wdata                   restitution, 9 bits
//
// One item per cycle when not stalled: 5 front stages, 25 divider stages
// (one quotient bit each), 3 back stages ending in the output register.
// Synchronous active-low reset clears valid bits and sets restitution to 1.0.
// A held output freezes every stage; in_ready follows, nothing is dropped.
module ball_pair_impulse_response (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpi_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bpi_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata
);

  localparam int QW = bpi_pkg::Q_W;

  logic [8:0]       restitution_r;
  logic             en;
  logic             f_v;
  bpi_pkg::front_t  f_d;
  logic [QW-1:0]    qpx, qpy, qwa, qwb;
  logic [QW-1:0]    vd_r;
  bpi_pkg::side_t   sd_r [QW];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restitution_r <= bpi_pkg::RESTITUTION_RST;
    end else if (cfg_we) begin
      restitution_r <= cfg_wdata;
    end
  end

  bpi_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_v        (in_valid),
    .in_item     (in_item),
    .restitution (restitution_r),
    .out_v       (f_v),
    .out_f       (f_d)
  );

  bpi_div u_div_px (.clk(clk), .en(en), .num(f_d.num_px), .den(f_d.den_p), .quo(qpx));
  bpi_div u_div_py (.clk(clk), .en(en), .num(f_d.num_py), .den(f_d.den_p), .quo(qpy));
  bpi_div u_div_wa (.clk(clk), .en(en), .num(f_d.num_wa), .den(f_d.den_w), .quo(qwa));
  bpi_div u_div_wb (.clk(clk), .en(en), .num(f_d.num_wb), .den(f_d.den_w), .quo(qwb));

  // carry valid and sideband alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (en) begin
      vd_r <= {vd_r[QW-2:0], f_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= f_d.side;
      for (int i = 1; i < QW; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  bpi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (vd_r[QW-1]),
    .qpx      (qpx),
    .qpy      (qpy),
    .qwa      (qwa),
    .qwb      (qwb),
    .side     (sd_r[QW-1]),
    .out_v    (out_valid),
    .out_item (out_item)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

  localparam int LATENCY     = 33;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_RANDOM  = 430;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  bpi_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  bpi_pkg::out_item_t out_item;
  logic               cfg_we;
  logic [8:0]         cfg_wdata;

  ball_pair_impulse_response dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  typedef struct {
    bpi_pkg::in_item_t  pair;
    logic               has_known;
    bpi_pkg::out_item_t known;
  } pair_row_t;

  bpi_pkg::out_item_t pending_velocities[$];
  logic [8:0] restitution_q;
  int         mismatches;
  int         results_seen;
  int         impulses_seen;
  int         touches_seen;
  int         cycle_count;
  int         idle_left;
  logic       no_idle;
  logic       hold_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic bpi_pkg::out_item_t collide_pair(bpi_pkg::in_item_t p, logic [8:0] rest);
    longint dx, dy, d2, rsum, vrx, vry, s, ma, mb, e, wa, wb, px, py;
    longint nax, nay, nbx, nby;
    logic touch, hit;
    bpi_pkg::out_item_t r;
    dx = longint'(p.b_pos_x) - longint'(p.a_pos_x);
    dy = longint'(p.b_pos_y) - longint'(p.a_pos_y);
    d2 = dx * dx + dy * dy;
    rsum = longint'(p.a_radius) + longint'(p.b_radius);
    touch = d2 < rsum * rsum;
    vrx = longint'(p.b_vel_x) - longint'(p.a_vel_x);
    vry = longint'(p.b_vel_y) - longint'(p.a_vel_y);
    s = vrx * dx + vry * dy;
    ma = longint'(p.a_radius) * longint'(p.a_radius);
    mb = longint'(p.b_radius) * longint'(p.b_radius);
    hit = touch && d2 != 0 && s < 0 && (ma + mb) != 0;
    nax = p.a_vel_x;
    nay = p.a_vel_y;
    nbx = p.b_vel_x;
    nby = p.b_vel_y;
    if (hit) begin
      e = (rest > bpi_pkg::RESTITUTION_MAX) ? 256 : longint'(rest);
      wa = round_div((256 + e) * mb * 256, ma + mb);
      wb = round_div((256 + e) * ma * 256, ma + mb);
      px = round_div(s * dx * 256, d2);
      py = round_div(s * dy * 256, d2);
      nax = nax + round_div(px * wa, 64'sd1 << 24);
      nay = nay + round_div(py * wa, 64'sd1 << 24);
      nbx = nbx - round_div(px * wb, 64'sd1 << 24);
      nby = nby - round_div(py * wb, 64'sd1 << 24);
    end
    r.new_a_vel_x = clamp16(nax);
    r.new_a_vel_y = clamp16(nay);
    r.new_b_vel_x = clamp16(nbx);
    r.new_b_vel_y = clamp16(nby);
    r.touching = touch;
    r.impulse_applied = hit;
    return r;
  endfunction

  function automatic bpi_pkg::in_item_t make_pair(int px0, int py0, int vx0, int vy0, int r0,
                                                  int px1, int py1, int vx1, int vy1, int r1);
    bpi_pkg::in_item_t p;
    p.a_pos_x = px0[15:0];
    p.a_pos_y = py0[15:0];
    p.a_vel_x = vx0[15:0];
    p.a_vel_y = vy0[15:0];
    p.a_radius = r0[11:0];
    p.b_pos_x = px1[15:0];
    p.b_pos_y = py1[15:0];
    p.b_vel_x = vx1[15:0];
    p.b_vel_y = vy1[15:0];
    p.b_radius = r1[11:0];
    return p;
  endfunction

  function automatic bpi_pkg::in_item_t random_pair();
    bpi_pkg::in_item_t p;
    int sep;
    p.a_pos_x = 16'($urandom);
    p.a_pos_y = 16'($urandom);
    p.a_vel_x = 16'($urandom);
    p.a_vel_y = 16'($urandom);
    p.b_vel_x = 16'($urandom);
    p.b_vel_y = 16'($urandom);
    p.a_radius = 12'($urandom);
    p.b_radius = 12'($urandom);
    p.b_pos_x = 16'($urandom);
    p.b_pos_y = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1: ;
      2: begin
        p.a_radius = 12'($urandom_range(0, 4095));
        p.b_radius = 12'($urandom_range(0, 4095));
        p.a_vel_x = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
        p.b_vel_x = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
        p.b_pos_x = 16'(int'(p.a_pos_x) + int'($urandom_range(0, 60)) - 30);
        p.b_pos_y = 16'(int'(p.a_pos_y) + int'($urandom_range(0, 60)) - 30);
      end
      default: begin
        p.a_radius = 12'($urandom_range(1, 400));
        p.b_radius = 12'($urandom_range(1, 400));
        sep = int'(p.a_radius) + int'(p.b_radius);
        p.b_pos_x = 16'(int'(p.a_pos_x) + int'($urandom_range(0, 2 * sep)) - sep);
        p.b_pos_y = 16'(int'(p.a_pos_y) + int'($urandom_range(0, 2 * sep)) - sep);
        p.a_vel_x = 16'(int'($urandom_range(0, 8191)) - 4096);
        p.a_vel_y = 16'(int'($urandom_range(0, 8191)) - 4096);
        p.b_vel_x = 16'(int'($urandom_range(0, 8191)) - 4096);
        p.b_vel_y = 16'(int'($urandom_range(0, 8191)) - 4096);
      end
    endcase
    return p;
  endfunction

  task automatic send_pair(bpi_pkg::in_item_t p);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pending_velocities.push_back(collide_pair(p, restitution_q));
    in_item <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_configure(logic [8:0] value);
    in_valid <= 1'b0;
    while (pending_velocities.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    restitution_q = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stall bursts, one long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      idle_left = 0;
    end else if (hold_out) begin
      out_ready <= 1'b0;
    end else if (idle_left > 0) begin
      out_ready <= 1'b0;
      idle_left--;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      idle_left = $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    bpi_pkg::out_item_t exp_v;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_item.impulse_applied) impulses_seen++;
      if (out_item.touching) touches_seen++;
      if (pending_velocities.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", out_item);
      end else begin
        exp_v = pending_velocities.pop_front();
        if (out_item !== exp_v) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", exp_v, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    pair_row_t rows[$];
    pair_row_t row;
    logic [8:0] rest_settings[4];
    bpi_pkg::in_item_t p;
    int i;
    hold_out = 1'b0;
    no_idle = 1'b0;
    mismatches = 0;
    results_seen = 0;
    impulses_seen = 0;
    touches_seen = 0;
    cycle_count = 0;
    idle_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    restitution_q = bpi_pkg::RESTITUTION_RST;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pass-through rows have known results; the rest use the predictor
    row.has_known = 1'b1;
    row.pair = make_pair(0, 0, 32767, -32768, 4095, 65535, 65535, -32768, 32767, 4095);
    row.known = {16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, 1'b0, 1'b0};
    rows.push_back(row);
    row.pair = make_pair(100, 100, 256, 0, 16, 100, 100, -256, 0, 16);
    row.known = {16'sd256, 16'sd0, -16'sd256, 16'sd0, 1'b1, 1'b0};
    rows.push_back(row);
    row.pair = make_pair(100, 100, -256, 0, 16, 110, 100, 256, 0, 16);
    row.known = {-16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1, 1'b0};
    rows.push_back(row);
    row.pair = make_pair(100, 100, 0, 0, 0, 100, 100, 0, 0, 0);
    row.known = {16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0};
    rows.push_back(row);
    row.pair = make_pair(100, 100, 5, 0, 0, 101, 100, 0, 0, 0);
    row.known = {16'sd5, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0};
    rows.push_back(row);
    row.has_known = 1'b0;
    row.pair = make_pair(100, 100, 256, 0, 16, 110, 100, -256, 0, 16);
    rows.push_back(row);
    row.pair = make_pair(100, 100, 0, 256, 16, 100, 120, 0, -256, 32);
    rows.push_back(row);
    row.pair = make_pair(100, 100, 32767, 32767, 4095, 140, 150, -32768, -32768, 4095);
    rows.push_back(row);
    row.pair = make_pair(65535, 65535, 0, 0, 4095, 65500, 65500, 32767, 32767, 1);
    rows.push_back(row);
    row.pair = make_pair(1000, 1000, 300, -20, 50, 1040, 1030, -100, 77, 0);
    rows.push_back(row);
    row.pair = make_pair(0, 0, 100, 100, 32, 64, 0, 0, 0, 32);
    rows.push_back(row);
    row.pair = make_pair(0, 0, 100, 100, 32, 63, 0, 0, 0, 32);
    rows.push_back(row);

    foreach (rows[k]) begin
      if (rows[k].has_known && collide_pair(rows[k].pair, restitution_q) !== rows[k].known) begin
        mismatches++;
        $display("directed row %0d disagrees with predictor", k);
      end
      send_pair(rows[k].pair);
    end

    rest_settings[0] = 9'd0;
    rest_settings[1] = 9'd511;
    rest_settings[2] = 9'd128;
    rest_settings[3] = 9'd256;
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_configure(rest_settings[ph]);
      for (int k = 5; k < rows.size(); k++) send_pair(rows[k].pair);
      for (i = 0; i < NUM_RANDOM / 4; i++) begin
        if (ph == 1 && i == 20) hold_out = 1'b1;
        if (ph == 3 && i >= NUM_RANDOM / 8) no_idle = 1'b1;
        p = random_pair();
        send_pair(p);
      end
      if (ph == 2) drain_and_configure(9'($urandom_range(257, 511)));
    end
    in_valid <= 1'b0;
    while (pending_velocities.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    $display("results checked: %0d, touching: %0d, impulses: %0d", results_seen,
             touches_seen, impulses_seen);
    $display("restitution settings 0, 128, 256 and above 256 exercised");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // long receiver hold while sender keeps offering
  always @(negedge clk) begin
    if (hold_out) begin
      repeat (120) @(negedge clk);
      hold_out <= 1'b0;
    end
  end

endmodule

// ===== ball_pair_impulse_response.f =====
rtl/bpi_pkg.sv
rtl/bpi_front.sv
rtl/bpi_div.sv
rtl/bpi_back.sv
rtl/ball_pair_impulse_response.sv
tb/sv/testbench.sv
